[rtl/spcq_pkg.sv]
// ----------------------------------------------------------------------------
// spcq_pkg
// Shared types and constants of the servo pulse capture qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package spcq_pkg;

  localparam int unsigned FailsafeUsDefault   = 1500;
  localparam int unsigned WindowBandUsDefault = 8;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_CAPTURE_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CAPTURE_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_LOWER = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_UPPER = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_CENTER = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_DIAG_ONLY   = 3'd6;

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_POLL = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  localparam logic [15:0] FRAME_MIN_US         = 16'd500;
  localparam logic [15:0] FRAME_MAX_US         = 16'd30000;
  localparam logic [15:0] CONTROL_FRAME_MIN_US = 16'd3000;
  localparam logic [15:0] WINDOW_EMPTY         = 16'hFFFF;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned ResW     = 146;

  typedef struct packed {
    logic [15:0] capture_min_us;
    logic [15:0] capture_max_us;
    logic [15:0] timeout_ms;
    logic [15:0] clamp_lo;
    logic [15:0] pulse_upper_us;
    logic [15:0] center_cmd;
    logic        diag_only;
  } cfg_t;

  typedef struct packed {
    logic [15:0] rise_stamp;
    logic [15:0] period;
    logic [15:0] raw_pulse;
    logic [15:0] accepted_pulse;
    logic [15:0] window_min;
    logic [15:0] window_max;
    logic [31:0] accept_stamp_ms;
    logic [31:0] edges_seen;
    logic [31:0] pulses_taken;
    logic        valid;
    logic        await_fall;
    logic        rise_seen;
  } state_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] cap_stamp;
  } in_t;

  typedef struct packed {
    logic [31:0] pulses_total;
    logic [31:0] edges_total;
    logic [15:0] raw_window_us;
    logic [15:0] frame_period;
    logic [15:0] legal_pulse;
    logic [15:0] held_pulse;
    logic        pulse_valid;
    logic        fresh;
    logic [15:0] command_us;
  } res_t;

endpackage

`default_nettype wire

[rtl/spcq_cfg.sv]
// ----------------------------------------------------------------------------
// spcq_cfg
// Configuration register file, written by index with no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module spcq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [spcq_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [spcq_pkg::CfgW-1:0]     cfg_data_i,
  output spcq_pkg::cfg_t                     cfg_o
);
  import spcq_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CAPTURE_MIN:  cfg_d.capture_min_us  = cfg_data_i;
        CFG_CAPTURE_MAX:  cfg_d.capture_max_us  = cfg_data_i;
        CFG_TIMEOUT:      cfg_d.timeout_ms      = cfg_data_i;
        CFG_PULSE_LOWER:  cfg_d.clamp_lo        = cfg_data_i;
        CFG_PULSE_UPPER:  cfg_d.pulse_upper_us  = cfg_data_i;
        CFG_PULSE_CENTER: cfg_d.center_cmd      = cfg_data_i;
        CFG_DIAG_ONLY:    cfg_d.diag_only       = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_min_us  <= 16'd500;
      cfg_q.capture_max_us  <= 16'd2500;
      cfg_q.timeout_ms      <= 16'd100;
      cfg_q.clamp_lo        <= 16'd1000;
      cfg_q.pulse_upper_us  <= 16'd2000;
      cfg_q.center_cmd      <= 16'd1500;
      cfg_q.diag_only       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/spcq_edge.sv]
// ----------------------------------------------------------------------------
// spcq_edge
// Edge tracker: period and width measurement, qualification, jitter window
// and accepted pulse state, updated once per processed item.
// ----------------------------------------------------------------------------
`default_nettype none

module spcq_edge #(
  parameter int unsigned FailsafeUs   = spcq_pkg::FailsafeUsDefault,
  parameter int unsigned WindowBandUs = spcq_pkg::WindowBandUsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [1:0]      cmd_i,
  input  wire logic [15:0]     cap_stamp_i,
  input  wire logic [31:0]     now_ms_i,
  input  spcq_pkg::cfg_t       cfg_i,
  output spcq_pkg::state_t     st_d_o,
  output logic [15:0]          span_o
);
  import spcq_pkg::*;

  localparam state_t StReset = '{
    rise_stamp:      16'd0,
    period:          16'd0,
    raw_pulse:       16'(FailsafeUs),
    accepted_pulse:  16'(FailsafeUs),
    window_min:      WINDOW_EMPTY,
    window_max:      16'd0,
    accept_stamp_ms: 32'd0,
    edges_seen:      32'd0,
    pulses_taken:    32'd0,
    valid:           1'b0,
    await_fall:      1'b0,
    rise_seen:       1'b0
  };

  localparam logic [15:0] Band = 16'(WindowBandUs);

  state_t      st_q;
  state_t      st_d;
  logic [15:0] width;
  logic [15:0] deviation;
  logic        qualified;

  assign width = cap_stamp_i - st_q.rise_stamp;
  assign deviation = (width >= st_q.accepted_pulse) ? width - st_q.accepted_pulse
                                                    : st_q.accepted_pulse - width;
  assign qualified = (width >= cfg_i.capture_min_us) && (width <= cfg_i.capture_max_us) &&
                     (width < st_q.period) && (st_q.period >= FRAME_MIN_US) &&
                     (st_q.period <= FRAME_MAX_US);

  always_comb begin
    st_d   = st_q;
    span_o = 16'd0;
    case (cmd_i)
      CMD_EDGE: begin
        st_d.edges_seen = st_q.edges_seen + 32'd1;
        if (!st_q.await_fall) begin
          if (st_q.rise_seen) begin
            st_d.period = width;
          end
          st_d.rise_stamp = cap_stamp_i;
          st_d.rise_seen  = 1'b1;
          st_d.await_fall = 1'b1;
        end else begin
          st_d.await_fall = 1'b0;
          if (qualified) begin
            st_d.raw_pulse = width;
            if (!st_q.valid || deviation <= Band) begin
              if (width < st_q.window_min) st_d.window_min = width;
              if (width > st_q.window_max) st_d.window_max = width;
            end
            if (st_q.period >= CONTROL_FRAME_MIN_US && !cfg_i.diag_only) begin
              st_d.accepted_pulse  = width;
              st_d.valid           = 1'b1;
              st_d.window_min      = width;
              st_d.window_max      = width;
              st_d.accept_stamp_ms = now_ms_i;
              st_d.pulses_taken    = st_q.pulses_taken + 32'd1;
            end
          end
        end
      end
      CMD_TAKE: begin
        if (st_q.window_min != WINDOW_EMPTY && st_q.window_max >= st_q.window_min) begin
          span_o = st_q.window_max - st_q.window_min;
        end
        st_d.window_min = WINDOW_EMPTY;
        st_d.window_max = 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  assign st_d_o = st_d;

endmodule

`default_nettype wire

[rtl/spcq_status.sv]
// ----------------------------------------------------------------------------
// spcq_status
// Freshness check and command clamp on the updated pulse state.
// ----------------------------------------------------------------------------
`default_nettype none

module spcq_status (
  input  spcq_pkg::state_t  st_i,
  input  spcq_pkg::cfg_t    cfg_i,
  input  wire logic [31:0]  now_ms_i,
  output logic [15:0]       command_us_o,
  output logic              fresh_o
);
  import spcq_pkg::*;

  logic [31:0] age;

  assign age     = now_ms_i - st_i.accept_stamp_ms;
  assign fresh_o = st_i.valid && (age <= {16'd0, cfg_i.timeout_ms});

  always_comb begin
    if (!fresh_o) begin
      command_us_o = cfg_i.center_cmd;
    end else if (st_i.accepted_pulse < cfg_i.clamp_lo) begin
      command_us_o = cfg_i.clamp_lo;
    end else if (st_i.accepted_pulse > cfg_i.pulse_upper_us) begin
      command_us_o = cfg_i.pulse_upper_us;
    end else begin
      command_us_o = st_i.accepted_pulse;
    end
  end

endmodule

`default_nettype wire

[rtl/servo_pulse_capture_qualifier_top.sv]
// ----------------------------------------------------------------------------
// servo_pulse_capture_qualifier_top
// Path from input transfer to result valid: input register, then update
// and result register. Throughput: one item per cycle unless the output
// stalls; the state update of one item is complete before the next leaves
// the input register. Reset (async, active low) restores the register
// defaults and the failsafe pulse state and empties both pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_capture_qualifier_top #(
  parameter int unsigned FailsafeUs   = spcq_pkg::FailsafeUsDefault,
  parameter int unsigned WindowBandUs = spcq_pkg::WindowBandUsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // cap_stamp [15:0], now_ms [47:16]
  input  wire logic [spcq_pkg::InDataW-1:0]   s_axis_tdata_i,
  // command [1:0]
  input  wire logic [1:0]                     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // command_us [15:0], fresh [16], pulse_valid [17], held_pulse [33:18],
  // legal_pulse [49:34], frame_period [65:50], raw_window_us [81:66],
  // edges_total [113:82], pulses_total [145:114], zero [151:146]
  output logic [spcq_pkg::OutDataW-1:0]       m_axis_tdata_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [spcq_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  wire logic [spcq_pkg::CfgW-1:0]      cfg_data_i
);
  import spcq_pkg::*;

  cfg_t        cfg;
  state_t      st_d;
  logic [15:0] span;
  logic [15:0] command_us;
  logic        fresh;

  logic        in_v_q;
  logic [1:0]  in_cmd_q;
  in_t         in_q;
  logic        out_v_q;
  res_t        res_q;
  res_t        res_d;
  logic        advance;
  logic        fire;

  assign advance         = !out_v_q || m_axis_tready_i;
  assign fire            = in_v_q && advance;
  assign s_axis_tready_o = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q <= s_axis_tuser_i;
      in_q     <= in_t'(s_axis_tdata_i);
    end
  end

  spcq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  spcq_edge #(
    .FailsafeUs   (FailsafeUs),
    .WindowBandUs (WindowBandUs)
  ) u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (in_cmd_q),
    .cap_stamp_i  (in_q.cap_stamp),
    .now_ms_i     (in_q.now_ms),
    .cfg_i        (cfg),
    .st_d_o       (st_d),
    .span_o       (span)
  );

  spcq_status u_status (
    .st_i         (st_d),
    .cfg_i        (cfg),
    .now_ms_i     (in_q.now_ms),
    .command_us_o (command_us),
    .fresh_o      (fresh)
  );

  always_comb begin
    res_d.pulses_total  = st_d.pulses_taken;
    res_d.edges_total   = st_d.edges_seen;
    res_d.raw_window_us = span;
    res_d.frame_period  = st_d.period;
    res_d.legal_pulse   = st_d.raw_pulse;
    res_d.held_pulse    = st_d.accepted_pulse;
    res_d.pulse_valid   = st_d.valid;
    res_d.fresh         = fresh;
    res_d.command_us    = command_us;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(OutDataW - ResW)'(0), res_q};

  a_fire_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_v_q)
    else $error("processed item did not reach the result register");

  a_fresh_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.fresh |-> res_q.pulse_valid)
    else $error("fresh result without an accepted pulse");

  a_count_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.pulses_total != 32'd0 |-> res_q.pulse_valid)
    else $error("pulse count advanced without an accepted pulse");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && res_q.pulse_valid |->
      {1'b0, res_q.raw_window_us} <= 17'(2 * WindowBandUs))
    else $error("jitter window wider than twice the band");

endmodule

`default_nettype wire
